/* rtl/dep_pkg.sv */
// Shared constants and codes for the dominated edge pruner.
package dep_pkg;

  localparam int MAX_VERTICES = 65536;
  localparam int MAX_EDGES    = 1048576;
  localparam int VERT_W       = 17;
  localparam int EDGE_W       = 20;
  localparam int CNT_W        = 21;
  localparam int COL_W        = 16;
  localparam int WGT_W        = 31;
  localparam int OFF_DEPTH    = MAX_VERTICES + 1;
  localparam int EDGE_DATA_W  = COL_W + WGT_W;
  localparam int IN_DATA_W    = 112;
  localparam int OUT_DATA_W   = 112;

  typedef enum logic [2:0] {
    OP_MAIN_OFFSET = 3'd0,
    OP_MAIN_EDGE   = 3'd1,
    OP_BASE_OFFSET = 3'd2,
    OP_BASE_EDGE   = 3'd3,
    OP_DECIDE      = 3'd4,
    OP_ROW_MARK    = 3'd5
  } op_t;

  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_MAX_DEG = 2'd1;
  localparam logic [1:0] CFG_PROTECT = 2'd2;

  localparam logic [1:0] MODE_SSWP = 2'd2;

endpackage

/* rtl/dominated_edge_pruner_top.sv */
// Dominated edge pruner: graph memories, decide sequencer and result register.
//
// Usage:
//  - s_axis carries one item per transfer; tuser holds the op code, tdata the
//    vertex, edge index, offset value, neighbor column and weight.
//  - Load ops (offsets and edges of the main and base graph) are written to
//    the memories in the cycle of their transfer and produce no result.
//  - A decide op reads the edge, optionally binary-searches the base row of
//    the owning vertex, then scans the smaller endpoint row; each scanned
//    neighbor that is no endpoint and whose weight does not already rule it
//    out is looked up in the larger row by binary search. A memory read
//    passes through a wait state before its data is used, and each search
//    probe adds a compare step. A self loop returns without a scan.
//  - A row mark returns the kept count as its output position.
//  - One item is in work at a time; s_axis_tready is high only while idle,
//    which is again the cycle after the result enters the output register.
//  - Results sit in an output register; a stalled receiver holds the
//    sequencer in its final step until the register frees up.
//  - Reset clears the counters, the control state and the config registers
//    to their defaults (sssp, degree cap 256, protection off). Memory
//    contents are undefined until loaded. The cfg channel is always ready.
module dominated_edge_pruner_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: vertex[16:0], edge_index[36:17], offset_value[57:37],
  //        neighbor_column[73:58], edge_weight[104:74], zero fill
  input  logic [dep_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op[2:0]
  input  logic [2:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: keep[0], was_protected[1], out_position[22:2], out_column[38:23],
  //        out_weight[69:39], removed_total[90:70], protected_total[111:91]
  output logic [dep_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_EDGE_USE, S_P_LO_USE, S_P_HI_USE, S_PROT_CHK,
    S_M_START, S_M_VLO_USE, S_M_VHI_USE, S_M_NLO_USE, S_M_NHI_USE, S_M_SEL,
    S_SCAN, S_SCAN_USE, S_SCAN_CHK, S_LK_LOOP, S_LK_CMP, S_LK_FINAL, S_EMIT
  } state_t;

  localparam int CW = dep_pkg::CNT_W;
  localparam logic [CW-1:0] EDGE_LIMIT = CW'(dep_pkg::MAX_EDGES);

  // input field split
  logic [dep_pkg::VERT_W-1:0] in_vertex;
  logic [dep_pkg::EDGE_W-1:0] in_edge;
  logic [CW-1:0]              in_offset;
  logic [dep_pkg::COL_W-1:0]  in_col;
  logic [dep_pkg::WGT_W-1:0]  in_wgt;
  dep_pkg::op_t               in_op;
  logic                       in_xfer;

  assign in_vertex = s_axis_tdata[16:0];
  assign in_edge   = s_axis_tdata[36:17];
  assign in_offset = s_axis_tdata[57:37];
  assign in_col    = s_axis_tdata[73:58];
  assign in_wgt    = s_axis_tdata[104:74];
  assign in_op     = dep_pkg::op_t'(s_axis_tuser);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // memories: offsets and packed {weight, column} edges
  logic [CW-1:0]                       main_off [0:dep_pkg::OFF_DEPTH-1];
  logic [CW-1:0]                       base_off [0:dep_pkg::OFF_DEPTH-1];
  logic [dep_pkg::EDGE_DATA_W-1:0]     main_edge [0:dep_pkg::MAX_EDGES-1];
  logic [dep_pkg::EDGE_DATA_W-1:0]     base_edge [0:dep_pkg::MAX_EDGES-1];

  logic [dep_pkg::VERT_W-1:0]      moff_addr, boff_addr;
  logic [dep_pkg::EDGE_W-1:0]      medge_addr, bedge_addr;
  logic [CW-1:0]                   moff_q, boff_q;
  logic [dep_pkg::EDGE_DATA_W-1:0] medge_q, bedge_q;

  logic off_in_range;
  assign off_in_range = ({1'b0, in_vertex} <= (dep_pkg::VERT_W + 1)'(dep_pkg::MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (in_xfer && in_op == dep_pkg::OP_MAIN_OFFSET && off_in_range) begin
      main_off[in_vertex] <= in_offset;
    end
    moff_q <= main_off[moff_addr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_op == dep_pkg::OP_BASE_OFFSET && off_in_range) begin
      base_off[in_vertex] <= in_offset;
    end
    boff_q <= base_off[boff_addr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_op == dep_pkg::OP_MAIN_EDGE) begin
      main_edge[in_edge] <= {in_wgt, in_col};
    end
    medge_q <= main_edge[medge_addr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_op == dep_pkg::OP_BASE_EDGE) begin
      base_edge[in_edge] <= {in_wgt, in_col};
    end
    bedge_q <= base_edge[bedge_addr];
  end

  // row end clamp and start clamp
  function automatic logic [CW-1:0] clamp_hi(input logic [CW-1:0] hi);
    clamp_hi = (hi > EDGE_LIMIT) ? EDGE_LIMIT : hi;
  endfunction

  function automatic logic [CW-1:0] clamp_lo(input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi);
    logic [CW-1:0] h;
    h = clamp_hi(hi);
    clamp_lo = (lo > h) ? h : lo;
  endfunction

  // registers
  state_t state, after, lk_ret;
  logic [1:0]                 algorithm_mode;
  logic [15:0]                max_deg;
  logic                       protect_en;
  logic [dep_pkg::VERT_W-1:0] v;
  logic [dep_pkg::COL_W-1:0]  nb;
  logic [dep_pkg::WGT_W-1:0]  target;
  logic                       res_keep, res_prot, res_mark;
  logic [CW-1:0]              vlo, vhi, nlo, nhi;
  logic [CW-1:0]              c, se, lg_b, lg_e;
  logic [CW-1:0]              lk_first, lk_last, lk_count, lk_at;
  logic [dep_pkg::COL_W-1:0]  lk_key;
  logic                       lk_base, lk_found;
  logic [dep_pkg::WGT_W-1:0]  lk_w;
  logic [dep_pkg::WGT_W-1:0]  w1;
  logic [CW-1:0]              kept_count, removed_count, protected_count;
  logic                       out_valid;
  logic [dep_pkg::OUT_DATA_W-1:0] out_data;

  // combinational helpers
  logic                            minimum;
  logic [dep_pkg::EDGE_DATA_W-1:0] lk_q;
  logic [CW-1:0]                   lk_step, lk_probe;
  logic [CW-1:0]                   vb_c, ve_c, nb_c, ne_c, dv, dn, p_lo, p_hi;
  logic [dep_pkg::WGT_W:0]         path_sum;
  logic                            skip_mid, dom_hit, emit_fire;
  logic [CW-1:0]                   kept_next, removed_next, protected_next, pos;

  assign minimum  = (algorithm_mode != dep_pkg::MODE_SSWP);
  assign lk_q     = lk_base ? bedge_q : medge_q;
  assign lk_step  = lk_count >> 1;
  assign lk_probe = lk_first + lk_step;
  assign vb_c     = clamp_lo(vlo, vhi);
  assign ve_c     = clamp_hi(vhi);
  assign nb_c     = clamp_lo(nlo, nhi);
  assign ne_c     = clamp_hi(nhi);
  assign dv       = ve_c - vb_c;
  assign dn       = ne_c - nb_c;
  assign p_lo     = clamp_lo(vlo, boff_q);
  assign p_hi     = clamp_hi(boff_q);
  assign path_sum = {1'b0, w1} + {1'b0, lk_w};
  assign skip_mid = ({1'b0, medge_q[15:0]} == v) || (medge_q[15:0] == nb) ||
                    (minimum ? (medge_q[46:16] >= target) : (medge_q[46:16] <= target));
  assign dom_hit  = lk_found && (minimum ?
                    ((lk_w != '0) && (path_sum <= {1'b0, target})) : (lk_w > target));
  // result enters the output register when it is empty or drains this cycle
  assign emit_fire = (state == S_EMIT) && (!out_valid || m_axis_tready);

  always_comb begin
    kept_next      = kept_count;
    removed_next   = removed_count;
    protected_next = protected_count;
    pos            = '0;
    if (res_mark) begin
      pos = kept_count;
    end else begin
      if (res_prot) protected_next = protected_count + 1'b1;
      if (!res_keep) removed_next = removed_count + 1'b1;
      if (res_keep) begin
        pos       = kept_count;
        kept_next = kept_count + 1'b1;
      end
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      after           <= S_IDLE;
      lk_ret          <= S_IDLE;
      algorithm_mode  <= 2'd1;
      max_deg         <= 16'd256;
      protect_en      <= 1'b0;
      kept_count      <= '0;
      removed_count   <= '0;
      protected_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          dep_pkg::CFG_MODE:    algorithm_mode <= cfg_data[1:0];
          dep_pkg::CFG_MAX_DEG: max_deg        <= cfg_data;
          dep_pkg::CFG_PROTECT: protect_en     <= cfg_data[0];
          default: ;
        endcase
      end
      if (emit_fire) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            res_keep <= 1'b1;
            res_prot <= 1'b0;
            res_mark <= (in_op == dep_pkg::OP_ROW_MARK);
            v        <= in_vertex;
            case (in_op)
              dep_pkg::OP_DECIDE: begin
                if (!in_vertex[16]) begin
                  medge_addr <= in_edge;
                  after      <= S_EDGE_USE;
                  state      <= S_WAIT;
                end
              end
              dep_pkg::OP_ROW_MARK: begin
                state <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_WAIT: state <= after;
        S_EDGE_USE: begin
          nb     <= medge_q[15:0];
          target <= medge_q[46:16];
          if ({1'b0, medge_q[15:0]} == v) begin
            state <= S_EMIT;
          end else if (protect_en) begin
            boff_addr <= v;
            after     <= S_P_LO_USE;
            state     <= S_WAIT;
          end else begin
            state <= S_M_START;
          end
        end
        S_P_LO_USE: begin
          vlo       <= boff_q;
          boff_addr <= v + 1'b1;
          after     <= S_P_HI_USE;
          state     <= S_WAIT;
        end
        S_P_HI_USE: begin
          lk_first <= p_lo;
          lk_last  <= p_hi;
          lk_count <= p_hi - p_lo;
          lk_key   <= nb;
          lk_base  <= 1'b1;
          lk_found <= 1'b0;
          lk_ret   <= S_PROT_CHK;
          state    <= S_LK_LOOP;
        end
        S_PROT_CHK: begin
          if (!lk_found || lk_w != target) begin
            res_prot <= 1'b1;
            state    <= S_EMIT;
          end else begin
            state <= S_M_START;
          end
        end
        S_M_START: begin
          moff_addr <= v;
          after     <= S_M_VLO_USE;
          state     <= S_WAIT;
        end
        S_M_VLO_USE: begin
          vlo       <= moff_q;
          moff_addr <= v + 1'b1;
          after     <= S_M_VHI_USE;
          state     <= S_WAIT;
        end
        S_M_VHI_USE: begin
          vhi       <= moff_q;
          moff_addr <= {1'b0, nb};
          after     <= S_M_NLO_USE;
          state     <= S_WAIT;
        end
        S_M_NLO_USE: begin
          nlo       <= moff_q;
          moff_addr <= {1'b0, nb} + 1'b1;
          after     <= S_M_NHI_USE;
          state     <= S_WAIT;
        end
        S_M_NHI_USE: begin
          nhi   <= moff_q;
          state <= S_M_SEL;
        end
        S_M_SEL: begin
          // scan the smaller row, search the larger one
          if (dv <= dn) begin
            c    <= vb_c;
            se   <= ve_c;
            lg_b <= nb_c;
            lg_e <= ne_c;
          end else begin
            c    <= nb_c;
            se   <= ne_c;
            lg_b <= vb_c;
            lg_e <= ve_c;
          end
          if (((dv <= dn) ? dv : dn) > {5'b0, max_deg}) state <= S_EMIT;
          else state <= S_SCAN;
        end
        S_SCAN: begin
          if (c >= se) begin
            state <= S_EMIT;
          end else begin
            medge_addr <= c[dep_pkg::EDGE_W-1:0];
            after      <= S_SCAN_USE;
            state      <= S_WAIT;
          end
        end
        S_SCAN_USE: begin
          c  <= c + 1'b1;
          w1 <= medge_q[46:16];
          if (skip_mid) begin
            state <= S_SCAN;
          end else begin
            lk_first <= lg_b;
            lk_last  <= lg_e;
            lk_count <= lg_e - lg_b;
            lk_key   <= medge_q[15:0];
            lk_base  <= 1'b0;
            lk_found <= 1'b0;
            lk_ret   <= S_SCAN_CHK;
            state    <= S_LK_LOOP;
          end
        end
        S_SCAN_CHK: begin
          if (dom_hit) begin
            res_keep <= 1'b0;
            state    <= S_EMIT;
          end else begin
            state <= S_SCAN;
          end
        end
        // lower-bound binary search over one row
        S_LK_LOOP: begin
          if (lk_count != '0) begin
            lk_at      <= lk_probe;
            medge_addr <= lk_probe[dep_pkg::EDGE_W-1:0];
            bedge_addr <= lk_probe[dep_pkg::EDGE_W-1:0];
            after      <= S_LK_CMP;
            state      <= S_WAIT;
          end else if (lk_first == lk_last) begin
            lk_found <= 1'b0;
            state    <= lk_ret;
          end else begin
            medge_addr <= lk_first[dep_pkg::EDGE_W-1:0];
            bedge_addr <= lk_first[dep_pkg::EDGE_W-1:0];
            after      <= S_LK_FINAL;
            state      <= S_WAIT;
          end
        end
        S_LK_CMP: begin
          if (lk_q[15:0] < lk_key) begin
            lk_first <= lk_at + 1'b1;
            lk_count <= lk_count - lk_step - 1'b1;
          end else begin
            lk_count <= lk_step;
          end
          state <= S_LK_LOOP;
        end
        S_LK_FINAL: begin
          lk_found <= (lk_q[15:0] == lk_key);
          lk_w     <= lk_q[46:16];
          state    <= lk_ret;
        end
        S_EMIT: begin
          if (emit_fire) begin
            kept_count      <= kept_next;
            removed_count   <= removed_next;
            protected_count <= protected_next;
            out_data        <= {protected_next, removed_next,
                                res_mark ? {dep_pkg::WGT_W{1'b0}} : target,
                                res_mark ? {dep_pkg::COL_W{1'b0}} : nb,
                                pos,
                                res_prot && !res_mark,
                                res_keep && !res_mark};
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
